>>> rtl/core/rrss_pkg.sv
// Shared types and constants for the round-robin slice scheduler.
// No dependencies; compile first.
package rrss_pkg;

    localparam int BURST_W   = 16;
    localparam int QUANTUM_W = 16;
    localparam int CLOCK_W   = 20;
    localparam int ACTION_W  = 2;

    localparam logic [QUANTUM_W-1:0] QUANTUM_RESET = 16'd10;

    localparam logic [ACTION_W-1:0] ACT_CLEAR   = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_APPEND  = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_ADVANCE = 2'd2;

    // controller -> datapath
    typedef struct packed {
        logic ready;
        logic clear;
        logic append;
        logic start_scan;
        logic step_scan;
        logic grant_calc;
        logic grant_commit;
        logic emit;
    } rrss_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic                in_valid;
        logic [ACTION_W-1:0] action;
        logic                none_pending;
        logic                rem_zero;
        logic                out_free;
    } rrss_status_t;

endpackage

>>> rtl/core/rrss_if.sv
// Valid/ready channels of the slice scheduler: request word and result word.
// Depends on rrss_pkg for field widths.
interface rrss_in_if;
    logic                               valid;
    logic                               ready;
    logic [rrss_pkg::ACTION_W-1:0]      action;
    logic [rrss_pkg::BURST_W-1:0]       burst_length;

    modport source (output valid, output action, output burst_length, input ready);
    modport sink   (input valid, input action, input burst_length, output ready);
endinterface

// NUM_W must equal $clog2(MAX_TASKS + 1) of the scheduler instance.
interface rrss_out_if #(parameter int NUM_W = 5);
    logic                               valid;
    logic                               ready;
    logic [NUM_W-1:0]                   task_number;
    logic [rrss_pkg::BURST_W-1:0]       slice_length;
    logic                               task_finished;
    logic [rrss_pkg::CLOCK_W-1:0]       waiting_time;
    logic                               all_done;
    logic                               table_full;

    modport source (output valid, output task_number, output slice_length,
                    output task_finished, output waiting_time, output all_done,
                    output table_full, input ready);
    modport sink   (input valid, input task_number, input slice_length,
                    input task_finished, input waiting_time, input all_done,
                    input table_full, output ready);
endinterface

>>> rtl/core/rrss_ctrl.sv
// Sequencing FSM of the slice scheduler: decode, table scan, grant, emit.
// Depends on rrss_pkg (command/status structs, action codes).
module rrss_ctrl
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  rrss_pkg::rrss_status_t status,
    output rrss_pkg::rrss_cmd_t    cmd
);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_DECIDE = 3'd1;
    localparam logic [2:0] ST_READ   = 3'd2;
    localparam logic [2:0] ST_CHECK  = 3'd3;
    localparam logic [2:0] ST_GRANT  = 3'd4;
    localparam logic [2:0] ST_EMIT   = 3'd5;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                cmd.ready = 1'b1;
                if (status.in_valid)
                begin
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE:
            begin
                state_next = ST_EMIT;
                unique case (status.action)
                    rrss_pkg::ACT_CLEAR:  cmd.clear  = 1'b1;
                    rrss_pkg::ACT_APPEND: cmd.append = 1'b1;
                    rrss_pkg::ACT_ADVANCE:
                    begin
                        // nothing pending: empty grant, state untouched
                        if (!status.none_pending)
                        begin
                            cmd.start_scan = 1'b1;
                            state_next     = ST_READ;
                        end
                    end
                    default: ;
                endcase
            end
            ST_READ:
            begin
                state_next = ST_CHECK;
            end
            ST_CHECK:
            begin
                if (status.rem_zero)
                begin
                    cmd.step_scan = 1'b1;
                    state_next    = ST_READ;
                end
                else
                begin
                    cmd.grant_calc = 1'b1;
                    state_next     = ST_GRANT;
                end
            end
            ST_GRANT:
            begin
                cmd.grant_commit = 1'b1;
                state_next       = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (status.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

>>> rtl/core/rrss_dp.sv
// Datapath of the slice scheduler: task tables, counters, clock, output word.
// Depends on rrss_pkg and the rrss_in_if / rrss_out_if channels.
module rrss_dp
#(
    parameter int MAX_TASKS = 16
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    rrss_in_if.sink                           task_req,
    rrss_out_if.source                        slice_rsp,
    input  logic                              cfg_we,
    input  logic [rrss_pkg::QUANTUM_W-1:0]    cfg_wdata,
    input  rrss_pkg::rrss_cmd_t               cmd,
    output rrss_pkg::rrss_status_t            status
);

    localparam int IDX_W = $clog2(MAX_TASKS);
    localparam int CNT_W = $clog2(MAX_TASKS + 1);
    localparam int BW    = rrss_pkg::BURST_W;
    localparam int CW    = rrss_pkg::CLOCK_W;

    logic [BW-1:0] rem_mem   [MAX_TASKS];
    logic [BW-1:0] burst_mem [MAX_TASKS];

    logic [rrss_pkg::QUANTUM_W-1:0] quantum_reg;
    logic [CNT_W-1:0]               task_count_reg;
    logic [CNT_W-1:0]               pending_reg;
    logic [IDX_W-1:0]               scan_reg;
    logic [CW-1:0]                  clock_reg;
    logic                           out_valid_reg;

    logic [rrss_pkg::ACTION_W-1:0]  action_reg;
    logic [BW-1:0]                  burst_reg;
    logic [IDX_W-1:0]               idx_reg;
    logic [BW-1:0]                  rem_rd_reg;
    logic [BW-1:0]                  burst_rd_reg;
    logic [BW-1:0]                  slice_reg;
    logic [CNT_W-1:0]               number_reg;
    logic                           finished_reg;
    logic                           full_reg;

    logic [CNT_W-1:0]               out_number_reg;
    logic [BW-1:0]                  out_slice_reg;
    logic                           out_finished_reg;
    logic [CW-1:0]                  out_wait_reg;
    logic                           out_done_reg;
    logic                           out_full_reg;

    logic                           load;
    logic                           table_is_full;
    logic                           store_task;
    logic [IDX_W-1:0]               count_idx;
    logic [IDX_W-1:0]               next_idx;
    logic [BW-1:0]                  quantum_eff;
    logic [BW-1:0]                  slice_calc;
    logic                           grant_done;
    logic                           mem_we;
    logic [IDX_W-1:0]               mem_waddr;
    logic [BW-1:0]                  mem_wdata;
    logic [CW-1:0]                  wait_calc;

    assign load          = task_req.valid & cmd.ready;
    assign table_is_full = (task_count_reg == CNT_W'(MAX_TASKS));
    assign store_task    = cmd.append & ~table_is_full;
    assign count_idx     = task_count_reg[IDX_W-1:0];

    // cyclic successor within the filled part of the table
    assign next_idx = ((CNT_W'(idx_reg) + CNT_W'(1)) == task_count_reg) ? '0
                      : idx_reg + IDX_W'(1);

    assign quantum_eff = (quantum_reg == '0) ? BW'(1) : quantum_reg;
    assign slice_calc  = (rem_rd_reg < quantum_eff) ? rem_rd_reg : quantum_eff;
    assign grant_done  = (rem_rd_reg == slice_reg);

    assign mem_we    = store_task | cmd.grant_commit;
    assign mem_waddr = cmd.grant_commit ? idx_reg : count_idx;
    assign mem_wdata = cmd.grant_commit ? (rem_rd_reg - slice_reg) : burst_reg;

    assign wait_calc = finished_reg ? (clock_reg - CW'(burst_rd_reg)) : '0;

    // task tables: one write port, registered read at the scan index
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            rem_mem[mem_waddr] <= mem_wdata;
        end
        if (store_task)
        begin
            burst_mem[count_idx] <= burst_reg;
        end
        rem_rd_reg   <= rem_mem[idx_reg];
        burst_rd_reg <= burst_mem[idx_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            quantum_reg    <= rrss_pkg::QUANTUM_RESET;
            task_count_reg <= '0;
            pending_reg    <= '0;
            scan_reg       <= '0;
            clock_reg      <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                quantum_reg <= cfg_wdata;
            end
            if (cmd.clear)
            begin
                task_count_reg <= '0;
                pending_reg    <= '0;
                scan_reg       <= '0;
                clock_reg      <= '0;
            end
            if (store_task)
            begin
                task_count_reg <= task_count_reg + CNT_W'(1);
                if (burst_reg != '0)
                begin
                    pending_reg <= pending_reg + CNT_W'(1);
                end
            end
            if (cmd.grant_commit)
            begin
                clock_reg <= clock_reg + CW'(slice_reg);
                scan_reg  <= next_idx;
                if (grant_done)
                begin
                    pending_reg <= pending_reg - CNT_W'(1);
                end
            end
            if (cmd.emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (slice_rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            action_reg   <= task_req.action;
            burst_reg    <= task_req.burst_length;
            number_reg   <= '0;
            slice_reg    <= '0;
            finished_reg <= 1'b0;
            full_reg     <= 1'b0;
        end
        if (cmd.append)
        begin
            full_reg <= table_is_full;
        end
        if (cmd.start_scan)
        begin
            idx_reg <= scan_reg;
        end
        if (cmd.step_scan)
        begin
            idx_reg <= next_idx;
        end
        if (cmd.grant_calc)
        begin
            slice_reg <= slice_calc;
        end
        if (cmd.grant_commit)
        begin
            finished_reg <= grant_done;
            number_reg   <= CNT_W'(idx_reg) + CNT_W'(1);
        end
        if (cmd.emit)
        begin
            out_number_reg   <= number_reg;
            out_slice_reg    <= slice_reg;
            out_finished_reg <= finished_reg;
            out_wait_reg     <= wait_calc;
            out_done_reg     <= (pending_reg == '0);
            out_full_reg     <= full_reg;
        end
    end

    assign task_req.ready          = cmd.ready;
    assign slice_rsp.valid         = out_valid_reg;
    assign slice_rsp.task_number   = out_number_reg;
    assign slice_rsp.slice_length  = out_slice_reg;
    assign slice_rsp.task_finished = out_finished_reg;
    assign slice_rsp.waiting_time  = out_wait_reg;
    assign slice_rsp.all_done      = out_done_reg;
    assign slice_rsp.table_full    = out_full_reg;

    assign status.in_valid     = task_req.valid;
    assign status.action       = action_reg;
    assign status.none_pending = (pending_reg == '0);
    assign status.rem_zero     = (rem_rd_reg == '0);
    assign status.out_free     = ~out_valid_reg | slice_rsp.ready;

`ifndef SYNTHESIS
    a_pending_le_count: assert property (@(posedge clk) disable iff (!rst_n)
        pending_reg <= task_count_reg)
        else $error("pending count exceeds task count");

    a_scan_in_table: assert property (@(posedge clk) disable iff (!rst_n)
        (task_count_reg == '0 && scan_reg == '0) || (CNT_W'(scan_reg) < task_count_reg))
        else $error("scan position outside filled table");

    a_grant_sane: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.grant_commit |-> (slice_reg != '0) && (slice_reg <= rem_rd_reg))
        else $error("grant larger than remaining time or empty");

    a_word_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(cmd.emit))
        else $error("result word appeared without emit");
`endif

endmodule

>>> rtl/core/round_robin_slice_scheduler_top.sv
// Top level of the round-robin time-slice scheduler.
// Depends on rrss_pkg, rrss_if (channels), rrss_ctrl and rrss_dp.

// Each request word (clear, append, advance) returns exactly one result word.
// Requests are handled one at a time; a finished word waits in an output
// register while the next request is taken. Clear, append, unused codes and an
// advance with nothing pending go from decode straight to emit; an advance that
// grants runs read and check once for each entry it visits, then grant and
// emit. The scan steps over S (0 to MAX_TASKS-1) table entries with no time
// left and reads the task table one entry at a time through its single
// registered read port. A new result word that finds the previous one still
// unaccepted holds the scheduler until that word is taken.
// The result interface's NUM_W must be $clog2(MAX_TASKS + 1). The quantum
// register resets to 10 and is written whenever cfg_we is high; write it
// only while no request is in flight.
module round_robin_slice_scheduler_top
#(
    parameter int MAX_TASKS = 16
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    rrss_in_if.sink                         task_req,
    rrss_out_if.source                      slice_rsp,
    input  logic                            cfg_we,
    input  logic [rrss_pkg::QUANTUM_W-1:0]  cfg_wdata
);

    rrss_pkg::rrss_cmd_t    cmd;
    rrss_pkg::rrss_status_t status;

    rrss_ctrl u_ctrl
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .status (status),
        .cmd    (cmd)
    );

    rrss_dp #(.MAX_TASKS(MAX_TASKS)) u_dp
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .task_req  (task_req),
        .slice_rsp (slice_rsp),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .cmd       (cmd),
        .status    (status)
    );

endmodule

>>> tb/testbench.sv
`timescale 1ns / 100ps
// Self-checking bench for round_robin_slice_scheduler_top: random request and result
// handshakes, an in-bench predictor of the slice table, and a per-field check of each word.
// Depends on rrss_pkg, rrss_in_if / rrss_out_if and the scheduler RTL.
module testbench;

    localparam int MAX_TASKS   = 16;
    localparam int NUM_W       = $clog2(MAX_TASKS + 1);
    localparam logic [rrss_pkg::ACTION_W-1:0] ACT_UNUSED = 2'd3;
    localparam int STUCK_LIMIT = 4000;
    localparam int HOLD_AT     = 120;
    localparam int HOLD_CYCLES = 300;
    localparam int DRAIN_CYCLES = 50;

    typedef struct packed {
        logic [NUM_W-1:0]               task_number;
        logic [rrss_pkg::BURST_W-1:0]   slice_length;
        logic                           task_finished;
        logic [rrss_pkg::CLOCK_W-1:0]   waiting_time;
        logic                           all_done;
        logic                           table_full;
    } slice_word_t;

    class slice_tracker;
        logic [rrss_pkg::QUANTUM_W-1:0] quantum;
        logic [rrss_pkg::BURST_W-1:0]   remaining[MAX_TASKS];
        logic [rrss_pkg::BURST_W-1:0]   original[MAX_TASKS];
        int                             count;
        int                             scan;
        logic [rrss_pkg::CLOCK_W-1:0]   clock_now;
        slice_word_t                    expected_slices[$];
        int                             errors;

        function new();
            quantum   = rrss_pkg::QUANTUM_RESET;
            count     = 0;
            scan      = 0;
            clock_now = '0;
            errors    = 0;
            foreach (remaining[i])
            begin
                remaining[i] = '0;
                original[i]  = '0;
            end
        endfunction

        function void set_quantum(logic [rrss_pkg::QUANTUM_W-1:0] value);
            quantum = value;
        endfunction

        function int pending();
            return expected_slices.size();
        endfunction

        // Predict the result word of one accepted request and update the table.
        function void take_request(logic [rrss_pkg::ACTION_W-1:0] action,
                                   logic [rrss_pkg::BURST_W-1:0] burst);
            slice_word_t                    r;
            logic [rrss_pkg::BURST_W-1:0]   q;
            logic [rrss_pkg::BURST_W-1:0]   grant;
            int                             idx;
            int                             start;
            bit                             found;
            bit                             busy;
            r     = '0;
            found = 0;
            busy  = 0;
            case (action)
                rrss_pkg::ACT_CLEAR:
                begin
                    count     = 0;
                    scan      = 0;
                    clock_now = '0;
                end
                rrss_pkg::ACT_APPEND:
                begin
                    if (count < MAX_TASKS)
                    begin
                        remaining[count] = burst;
                        original[count]  = burst;
                        count++;
                    end
                    else
                        r.table_full = 1'b1;
                end
                rrss_pkg::ACT_ADVANCE:
                begin
                    if (count != 0)
                    begin
                        start = scan % count;
                        for (int k = 0; k < count && !found; k++)
                        begin
                            idx = (start + k) % count;
                            if (remaining[idx] != 0)
                            begin
                                found = 1;
                                q = (quantum == 0) ? 16'd1 : quantum;
                                grant = (remaining[idx] < q) ? remaining[idx] : q;
                                remaining[idx] = remaining[idx] - grant;
                                clock_now = clock_now + rrss_pkg::CLOCK_W'(grant);
                                r.task_number  = NUM_W'(idx + 1);
                                r.slice_length = grant;
                                if (remaining[idx] == 0)
                                begin
                                    r.task_finished = 1'b1;
                                    r.waiting_time  = clock_now
                                                      - rrss_pkg::CLOCK_W'(original[idx]);
                                end
                                scan = (idx + 1) % count;
                            end
                        end
                    end
                end
                default:
                begin
                end
            endcase
            for (int i = 0; i < count; i++)
                if (remaining[i] != 0)
                    busy = 1;
            r.all_done = !busy;
            expected_slices.push_back(r);
        endfunction

        function void match_slice(slice_word_t got);
            slice_word_t exp_w;
            if (expected_slices.size() == 0)
            begin
                $error("result word with no request pending: %p", got);
                errors++;
                return;
            end
            exp_w = expected_slices.pop_front();
            if (got.task_number !== exp_w.task_number)
            begin
                $error("task_number: expected %0d, got %0d", exp_w.task_number, got.task_number);
                errors++;
            end
            if (got.slice_length !== exp_w.slice_length)
            begin
                $error("slice_length: expected %0d, got %0d",
                       exp_w.slice_length, got.slice_length);
                errors++;
            end
            if (got.task_finished !== exp_w.task_finished)
            begin
                $error("task_finished: expected %0d, got %0d",
                       exp_w.task_finished, got.task_finished);
                errors++;
            end
            if (got.waiting_time !== exp_w.waiting_time)
            begin
                $error("waiting_time: expected %0d, got %0d",
                       exp_w.waiting_time, got.waiting_time);
                errors++;
            end
            if (got.all_done !== exp_w.all_done)
            begin
                $error("all_done: expected %0d, got %0d", exp_w.all_done, got.all_done);
                errors++;
            end
            if (got.table_full !== exp_w.table_full)
            begin
                $error("table_full: expected %0d, got %0d", exp_w.table_full, got.table_full);
                errors++;
            end
        endfunction
    endclass

    logic                           clk;
    logic                           rst_n;
    logic                           cfg_we;
    logic [rrss_pkg::QUANTUM_W-1:0] cfg_wdata;
    bit                             quiet;
    int                             stuck;
    slice_tracker                   sb;

    rrss_in_if                    task_req_if();
    rrss_out_if #(.NUM_W(NUM_W))  slice_rsp_if();

    round_robin_slice_scheduler_top #(.MAX_TASKS(MAX_TASKS)) u_dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .task_req  (task_req_if),
        .slice_rsp (slice_rsp_if),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Watchdog: cycles in which neither channel moves a word.
    always @(posedge clk)
    begin
        if (!rst_n || (task_req_if.valid && task_req_if.ready)
            || (slice_rsp_if.valid && slice_rsp_if.ready))
            stuck <= 0;
        else
        begin
            stuck <= stuck + 1;
            if (stuck == STUCK_LIMIT)
            begin
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    task automatic send_word(logic [rrss_pkg::ACTION_W-1:0] action,
                             logic [rrss_pkg::BURST_W-1:0] burst);
        int gap;
        gap = quiet ? 0 : $urandom_range(0, 6);
        @(negedge clk);
        if (gap > 0)
        begin
            task_req_if.valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        task_req_if.valid        = 1'b1;
        task_req_if.action       = action;
        task_req_if.burst_length = burst;
        do
            @(posedge clk);
        while (!task_req_if.ready);
        sb.take_request(action, burst);
    endtask

    // Quantum is only changed with the scheduler drained.
    task automatic write_quantum(logic [rrss_pkg::QUANTUM_W-1:0] value);
        @(negedge clk);
        task_req_if.valid = 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
        @(negedge clk);
        cfg_we    = 1'b1;
        cfg_wdata = value;
        @(negedge clk);
        cfg_we = 1'b0;
        sb.set_quantum(value);
    endtask

    function automatic logic [rrss_pkg::BURST_W-1:0] pick_burst();
        int sel;
        sel = $urandom_range(0, 15);
        if (sel == 0)
            return '0;
        else if (sel == 1)
            return rrss_pkg::BURST_W'($urandom);
        else if (sel == 2)
            return '1;
        else
            return rrss_pkg::BURST_W'($urandom_range(1, 60));
    endfunction

    // Mostly clear / fill / advance runs with random content, plus stray words.
    task automatic run_phase(int n_items);
        int sent;
        int n_tasks;
        int n_adv;
        sent = 0;
        while (sent < n_items)
        begin
            send_word(rrss_pkg::ACT_CLEAR, rrss_pkg::BURST_W'($urandom));
            sent++;
            n_tasks = $urandom_range(1, MAX_TASKS + 1);
            for (int i = 0; i < n_tasks && sent < n_items; i++)
            begin
                send_word(rrss_pkg::ACT_APPEND, pick_burst());
                sent++;
            end
            n_adv = $urandom_range(4, 40);
            for (int i = 0; i < n_adv && sent < n_items; i++)
            begin
                if ($urandom_range(0, 15) == 0)
                    send_word(rrss_pkg::ACTION_W'($urandom_range(0, 3)),
                              rrss_pkg::BURST_W'($urandom));
                else
                    send_word(rrss_pkg::ACT_ADVANCE, rrss_pkg::BURST_W'($urandom));
                sent++;
            end
        end
    endtask

    // Result side: random stalls, one long hold-off to back up the input.
    initial
    begin
        int          stall;
        int          delivered;
        slice_word_t got;
        delivered = 0;
        slice_rsp_if.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            stall = quiet ? 0 : $urandom_range(0, 6);
            @(negedge clk);
            if (delivered == HOLD_AT)
            begin
                slice_rsp_if.ready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
            end
            else if (stall > 0)
            begin
                slice_rsp_if.ready = 1'b0;
                repeat (stall) @(negedge clk);
            end
            slice_rsp_if.ready = 1'b1;
            do
                @(posedge clk);
            while (!slice_rsp_if.valid);
            got.task_number   = slice_rsp_if.task_number;
            got.slice_length  = slice_rsp_if.slice_length;
            got.task_finished = slice_rsp_if.task_finished;
            got.waiting_time  = slice_rsp_if.waiting_time;
            got.all_done      = slice_rsp_if.all_done;
            got.table_full    = slice_rsp_if.table_full;
            sb.match_slice(got);
            delivered++;
        end
    end

    initial
    begin
        sb = new();
        quiet = 0;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        task_req_if.valid = 1'b0;
        task_req_if.action = rrss_pkg::ACT_CLEAR;
        task_req_if.burst_length = '0;
        repeat (12) @(negedge clk);
        rst_n = 1'b1;

        // Directed: empty table, unused code, zero and full-scale bursts,
        // zero-burst skip, then fill past capacity.
        send_word(rrss_pkg::ACT_ADVANCE, '0);
        send_word(ACT_UNUSED, '1);
        send_word(rrss_pkg::ACT_APPEND, '0);
        send_word(rrss_pkg::ACT_APPEND, '1);
        send_word(rrss_pkg::ACT_APPEND, 16'd25);
        send_word(rrss_pkg::ACT_ADVANCE, 16'h5555);
        send_word(ACT_UNUSED, '0);
        send_word(rrss_pkg::ACT_CLEAR, 16'hAAAA);
        for (int i = 0; i <= MAX_TASKS; i++)
            send_word(rrss_pkg::ACT_APPEND,
                      (i == MAX_TASKS) ? 16'hAAAA : rrss_pkg::BURST_W'(i + 1));

        write_quantum(16'd1);
        run_phase(65);
        write_quantum(16'hFFFF);
        run_phase(65);
        // zero quantum behaves as one
        write_quantum(16'd0);
        run_phase(60);
        quiet = 1;
        write_quantum(rrss_pkg::QUANTUM_W'($urandom_range(2, 40)));
        run_phase(60);
        quiet = 0;
        write_quantum(rrss_pkg::QUANTUM_W'($urandom_range(1, 65535)));
        run_phase(60);
        write_quantum(rrss_pkg::QUANTUM_RESET);
        run_phase(65);

        @(negedge clk);
        task_req_if.valid = 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
